### hdl/fwct_pkg.sv
// shared constants and control types for the wait channel table
package fwct_pkg;

  localparam int FWCT_ENTRIES = 64;

  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 48;
  localparam int VAL_W     = 32;
  localparam int CHAN_W    = 6;
  localparam int STAT_W    = 3;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_WAIT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WAKE_ALL = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ADDRESS = 3'd1;
  localparam logic [STAT_W-1:0] ST_MISMATCH    = 3'd2;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_ENTRY    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH = 1'b1;

  localparam logic [ADDR_W-1:0]  WIN_LOW_RESET  = '0;
  localparam logic [ADDR_W-1:0]  WIN_HIGH_RESET = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

  typedef struct packed {
    logic load;
    logic decode;
    logic scan_run;
    logic finish;
  } fwct_cmd_t;

  typedef struct packed {
    logic is_release;
    logic skip_scan;
    logic scan_done;
  } fwct_sts_t;

endpackage

### hdl/fwct_req_if.sv
// request channel: one command per transaction
interface fwct_req_if import fwct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [VAL_W-1:0]  expected_value;
  logic [VAL_W-1:0]  current_value;
  logic [VAL_W-1:0]  wake_limit;
  logic [CHAN_W-1:0] release_channel;

  modport source (output valid, command, address, expected_value, current_value,
                  wake_limit, release_channel, input ready);
  modport sink (input valid, command, address, expected_value, current_value,
                wake_limit, release_channel, output ready);
endinterface

### hdl/fwct_rsp_if.sv
// response channel: one result per transaction
interface fwct_rsp_if import fwct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [CHAN_W-1:0]  channel;
  logic [COUNT_W-1:0] wake_count;
  logic               wake_everyone;

  modport source (output valid, status, channel, wake_count, wake_everyone, input ready);
  modport sink (input valid, status, channel, wake_count, wake_everyone, output ready);
endinterface

### hdl/fwct_cfg_if.sv
// configuration write channel
interface fwct_cfg_if import fwct_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/fwct_ram.sv
// generic single write port, single read port ram with registered read
module fwct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/fwct_datapath.sv
// datapath: window registers, entry tables, scan pipeline and result register
module fwct_datapath import fwct_pkg::*; #(
  parameter int ENTRIES = FWCT_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fwct_cmd_t            cmd,
  output fwct_sts_t            sts,
  input  logic [CMD_W-1:0]     req_command,
  input  logic [ADDR_W-1:0]    req_address,
  input  logic [VAL_W-1:0]     req_expected_value,
  input  logic [VAL_W-1:0]     req_current_value,
  input  logic [VAL_W-1:0]     req_wake_limit,
  input  logic [CHAN_W-1:0]    req_release_channel,
  input  logic                 cfg_fire,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  output logic [STAT_W-1:0]    rsp_status,
  output logic [CHAN_W-1:0]    rsp_channel,
  output logic [COUNT_W-1:0]   rsp_wake_count,
  output logic                 rsp_wake_everyone
);

  // only slots reachable through a six bit channel are used
  localparam int USABLE = (ENTRIES < 64) ? ENTRIES : 64;
  localparam int IDX_W  = $clog2(USABLE);
  localparam int SCAN_W = $clog2(USABLE + 1);
  localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(USABLE);
  localparam logic [CHAN_W:0]   REL_LIMIT =
    (ENTRIES >= 64) ? (CHAN_W + 1)'(64) : (CHAN_W + 1)'(ENTRIES);

  logic [ADDR_W-1:0]  win_low;
  logic [ADDR_W-1:0]  win_high;
  logic [CMD_W-1:0]   lat_cmd;
  logic [ADDR_W-1:0]  lat_addr;
  logic [VAL_W-1:0]   lat_exp;
  logic [VAL_W-1:0]   lat_cur;
  logic [VAL_W-1:0]   lat_max;
  logic [CHAN_W-1:0]  lat_rel;
  logic               addr_bad;
  logic               val_bad;
  logic               addr_bad_c;
  logic               val_bad_c;
  logic [USABLE-1:0]  valid;
  logic [SCAN_W-1:0]  scan_idx;
  logic [IDX_W-1:0]   cmp_idx;
  logic               cmp_vld;
  logic               issue;
  logic               hit;
  logic [IDX_W-1:0]   hit_slot;
  logic               free_found;
  logic [IDX_W-1:0]   free_slot;
  logic [ADDR_W-1:0]  addr_rdata;
  logic [COUNT_W-1:0] cnt_rdata;
  logic [IDX_W-1:0]   rel_idx;
  logic               rel_ok;
  logic [IDX_W-1:0]   cnt_raddr;
  logic [VAL_W-1:0]   limit;

  logic [STAT_W-1:0]  status_next;
  logic [CHAN_W-1:0]  channel_next;
  logic [COUNT_W-1:0] wake_count_next;
  logic               wake_everyone_next;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic               addr_we;
  logic               set_valid;
  logic               clr_valid;
  logic [IDX_W-1:0]   vidx;

  assign rel_idx   = lat_rel[IDX_W-1:0];
  assign rel_ok    = {1'b0, lat_rel} < REL_LIMIT;
  assign cnt_raddr = (lat_cmd == CMD_RELEASE) ? rel_idx : hit_slot;
  assign issue     = scan_idx != SCAN_END;

  assign addr_bad_c = (lat_addr < win_low) ||
                      (({1'b0, lat_addr} + (ADDR_W + 1)'(4)) > {1'b0, win_high});
  assign val_bad_c  = lat_cur != lat_exp;

  assign sts.is_release = lat_cmd == CMD_RELEASE;
  assign sts.skip_scan  = (lat_cmd == CMD_WAIT) && (addr_bad_c || val_bad_c);
  assign sts.scan_done  = !issue && !cmp_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_low  <= WIN_LOW_RESET;
      win_high <= WIN_HIGH_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_WIN_LOW:  win_low  <= cfg_data;
        REG_WIN_HIGH: win_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_cmd  <= req_command;
      lat_addr <= req_address;
      lat_exp  <= req_expected_value;
      lat_cur  <= req_current_value;
      lat_max  <= req_wake_limit;
      lat_rel  <= req_release_channel;
    end
    if (cmd.decode) begin
      addr_bad <= addr_bad_c;
      val_bad  <= val_bad_c;
    end
  end

  // one entry read per cycle, compared in the next cycle against the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      cmp_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      scan_idx   <= '0;
      cmp_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan_run) begin
      if (issue) begin
        scan_idx <= scan_idx + SCAN_W'(1);
      end
      cmp_vld <= issue;
      cmp_idx <= scan_idx[IDX_W-1:0];
      if (cmp_vld) begin
        if (valid[cmp_idx] && (addr_rdata == lat_addr) && !hit) begin
          hit      <= 1'b1;
          hit_slot <= cmp_idx;
        end
        if (!valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= cmp_idx;
        end
      end
    end
  end

  always_comb begin
    status_next        = ST_OK;
    channel_next       = '0;
    wake_count_next    = '0;
    wake_everyone_next = 1'b0;
    cnt_we             = 1'b0;
    cnt_waddr          = hit_slot;
    cnt_wdata          = cnt_rdata + COUNT_W'(1);
    addr_we            = 1'b0;
    set_valid          = 1'b0;
    clr_valid          = 1'b0;
    vidx               = free_slot;
    limit              = lat_max[VAL_W-1] ? '0 : lat_max;
    unique case (lat_cmd)
      CMD_WAIT: begin
        if (addr_bad) begin
          status_next = ST_BAD_ADDRESS;
        end else if (val_bad) begin
          status_next = ST_MISMATCH;
        end else if (hit) begin
          if (cnt_rdata == COUNT_MAX) begin
            status_next = ST_TABLE_FULL;
          end else begin
            cnt_we       = 1'b1;
            channel_next = CHAN_W'(hit_slot);
          end
        end else if (free_found) begin
          cnt_we       = 1'b1;
          cnt_waddr    = free_slot;
          cnt_wdata    = COUNT_W'(1);
          addr_we      = 1'b1;
          set_valid    = 1'b1;
          channel_next = CHAN_W'(free_slot);
        end else begin
          status_next = ST_TABLE_FULL;
        end
      end
      CMD_RELEASE: begin
        channel_next = lat_rel;
        vidx         = rel_idx;
        cnt_waddr    = rel_idx;
        if (!rel_ok || !valid[rel_idx]) begin
          status_next = ST_NO_ENTRY;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - COUNT_W'(1) : '0;
          clr_valid = cnt_rdata <= COUNT_W'(1);
        end
      end
      CMD_WAKE: begin
        if (!hit) begin
          status_next = ST_NO_ENTRY;
        end else begin
          channel_next    = CHAN_W'(hit_slot);
          wake_count_next = ({{(VAL_W - COUNT_W){1'b0}}, cnt_rdata} < limit) ?
                            cnt_rdata : limit[COUNT_W-1:0];
        end
      end
      CMD_WAKE_ALL: begin
        if (!hit) begin
          status_next = ST_NO_ENTRY;
        end else begin
          channel_next       = CHAN_W'(hit_slot);
          wake_everyone_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.finish) begin
      if (set_valid) begin
        valid[vidx] <= 1'b1;
      end
      if (clr_valid) begin
        valid[vidx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_status        <= status_next;
      rsp_channel       <= channel_next;
      rsp_wake_count    <= wake_count_next;
      rsp_wake_everyone <= wake_everyone_next;
    end
  end

  fwct_ram #(.WIDTH(ADDR_W), .DEPTH(USABLE)) u_addr_ram (
    .clk   (clk),
    .we    (cmd.finish && addr_we),
    .waddr (free_slot),
    .wdata (lat_addr),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (addr_rdata)
  );

  fwct_ram #(.WIDTH(COUNT_W), .DEPTH(USABLE)) u_count_ram (
    .clk   (clk),
    .we    (cmd.finish && cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  a_hit_free_distinct: assert property (@(posedge clk) disable iff (rst)
    hit && free_found |-> hit_slot != free_slot)
    else $error("matching slot and free slot coincide");

  a_alloc_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && set_valid |=> valid[$past(vidx)])
    else $error("allocated slot not marked valid");

  a_wait_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && cnt_we && (lat_cmd == CMD_WAIT) |-> cnt_wdata != '0)
    else $error("wait left a zero waiter count");

endmodule

### hdl/fwct_ctrl.sv
// controller state machine sequencing one command at a time
module fwct_ctrl import fwct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output fwct_cmd_t cmd,
  input  fwct_sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_CNT_RD = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready    = state == S_IDLE;
  assign rsp_valid    = state == S_OUT;
  assign cmd.load     = req_valid && req_ready;
  assign cmd.decode   = state == S_DECODE;
  assign cmd.scan_run = state == S_SCAN;
  assign cmd.finish   = state == S_FINISH;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        priority if (sts.is_release) state_next = S_CNT_RD;
        else if (sts.skip_scan) state_next = S_FINISH;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_CNT_RD;
      end
      S_CNT_RD: state_next = S_FINISH;
      S_FINISH: state_next = S_OUT;
      S_OUT: begin
        if (rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_scan_to_count: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && sts.scan_done |=> state == S_CNT_RD)
    else $error("scan end did not move to count read");

  a_release_skips_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_DECODE && sts.is_release |=> state == S_CNT_RD)
    else $error("release entered the scan");

endmodule

### hdl/futex_wait_channel_table_unit.sv
// Wait channel table, top level. One command is handled at a time: a wait or
// wake passes from acceptance through decode, a scan of the address RAM that
// reads one entry per cycle, a count read and finish to the result state; a
// release skips the scan, and a wait refused for a bad address or value mismatch
// goes from decode straight to finish. The next command is accepted once the
// result transaction completes. Only the first 64 slots are used, since a channel
// is six bits wide. The slot tables need no clearing pass after reset;
// configuration writes are always taken.
module futex_wait_channel_table_unit import fwct_pkg::*; #(
  parameter int ENTRIES = FWCT_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  fwct_req_if.sink   req,
  fwct_rsp_if.source rsp,
  fwct_cfg_if.sink   cfg
);

  fwct_cmd_t cmd;
  fwct_sts_t sts;

  assign cfg.ready = 1'b1;

  fwct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fwct_datapath #(.ENTRIES(ENTRIES)) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .req_command         (req.command),
    .req_address         (req.address),
    .req_expected_value  (req.expected_value),
    .req_current_value   (req.current_value),
    .req_wake_limit      (req.wake_limit),
    .req_release_channel (req.release_channel),
    .cfg_fire            (cfg.valid && cfg.ready),
    .cfg_index           (cfg.index),
    .cfg_data            (cfg.data),
    .rsp_status          (rsp.status),
    .rsp_channel         (rsp.channel),
    .rsp_wake_count      (rsp.wake_count),
    .rsp_wake_everyone   (rsp.wake_everyone)
  );

endmodule
